>>> design/kleb_pkg.sv
// types, key codes and sizes shared by the line editor modules
// no dependencies
package kleb_pkg;

  localparam int LINE_MAX = 64;
  localparam int LEN_W    = 7;
  localparam int IDX_W    = 6;
  localparam int CH_W     = 7;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;

  localparam logic [LEN_W-1:0] LINE_MAX_LEN = LEN_W'(LINE_MAX);

  // raw key codes
  localparam logic [7:0] KEY_PREFIX_A = 8'h00;
  localparam logic [7:0] KEY_PREFIX_B = 8'hE0;
  localparam logic [7:0] KEY_LEFT     = 8'd75;
  localparam logic [7:0] KEY_RIGHT    = 8'd77;
  localparam logic [7:0] KEY_HOME     = 8'd71;
  localparam logic [7:0] KEY_END      = 8'd79;
  localparam logic [7:0] KEY_DEL      = 8'd83;
  localparam logic [7:0] KEY_BKSP     = 8'd8;
  localparam logic [7:0] KEY_ENTER    = 8'd13;
  localparam logic [7:0] KEY_ESC      = 8'd27;
  localparam logic [7:0] KEY_PRINT_LO = 8'd32;
  localparam logic [7:0] KEY_PRINT_HI = 8'd126;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  typedef enum logic [3:0] {
    OP_LEFT,
    OP_RIGHT,
    OP_HOME,
    OP_END,
    OP_DEL,
    OP_STATUS,
    OP_BKSP,
    OP_PRINT,
    OP_ENTER,
    OP_ESC
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [CH_W-1:0] ch;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SH_RD,
    B_SH_WR,
    B_EM_RD,
    B_EM_OUT,
    B_STATUS
  } back_state_t;

endpackage

>>> design/kleb_front.sv
// front end: tracks the extended-key prefix and turns raw bytes into commands
// depends on kleb_pkg
module kleb_front import kleb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       key_valid,
  output logic       key_stall,
  input  logic [7:0] key_byte,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic prefix;
  logic prefix_next;
  logic accept;
  logic is_prefix;

  assign key_stall = q_full;
  assign accept    = key_valid && !key_stall;
  assign is_prefix = (key_byte == KEY_PREFIX_A) || (key_byte == KEY_PREFIX_B);

  always_comb begin
    prefix_next = prefix;
    q_push      = 1'b0;
    q_cmd.ch    = key_byte[CH_W-1:0];
    q_cmd.op    = OP_STATUS;
    if (accept) begin
      if (prefix) begin
        prefix_next = 1'b0;
        q_push      = 1'b1;
        unique case (key_byte)
          KEY_LEFT:  q_cmd.op = OP_LEFT;
          KEY_RIGHT: q_cmd.op = OP_RIGHT;
          KEY_HOME:  q_cmd.op = OP_HOME;
          KEY_END:   q_cmd.op = OP_END;
          KEY_DEL:   q_cmd.op = OP_DEL;
          default:   q_cmd.op = OP_STATUS;
        endcase
      end else if (is_prefix) begin
        prefix_next = 1'b1;
      end else begin
        q_push = 1'b1;
        if (key_byte == KEY_BKSP) begin
          q_cmd.op = OP_BKSP;
        end else if (key_byte == KEY_ENTER) begin
          q_cmd.op = OP_ENTER;
        end else if (key_byte == KEY_ESC) begin
          q_cmd.op = OP_ESC;
        end else if (key_byte >= KEY_PRINT_LO && key_byte <= KEY_PRINT_HI) begin
          q_cmd.op = OP_PRINT;
        end else begin
          q_cmd.op = OP_STATUS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= 1'b0;
    end else begin
      prefix <= prefix_next;
    end
  end

endmodule

>>> design/kleb_queue.sv
// short command queue between the front end and the back end
// depends on kleb_pkg
module kleb_queue import kleb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/kleb_back.sv
// back end: line store, cursor and length, tail shifting, line read-out
// and the result register; depends on kleb_pkg
module kleb_back import kleb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [LEN_W-1:0]  cfg_data,
  input  logic              q_empty,
  input  cmd_t              q_head,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [1:0]        kind,
  output logic [CH_W-1:0]   char_out,
  output logic [IDX_W-1:0]  char_position,
  output logic [LEN_W-1:0]  cursor_pos,
  output logic [LEN_W-1:0]  line_length,
  output logic              terminator,
  output logic              last
);

  logic [CH_W-1:0]  mem [LINE_MAX];
  logic [CH_W-1:0]  rd_data;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic [CH_W-1:0]  wdata;
  logic             we;

  back_state_t      state;
  back_state_t      state_next;
  logic [LEN_W-1:0] max_width;
  logic [LEN_W-1:0] eff_width;
  logic [LEN_W-1:0] cursor;
  logic [LEN_W-1:0] cursor_next;
  logic [LEN_W-1:0] length;
  logic [LEN_W-1:0] length_next;
  logic [LEN_W-1:0] ptr;
  logic [LEN_W-1:0] ptr_next;
  logic [LEN_W-1:0] ptr_inc;
  logic             term;
  logic             term_next;
  logic             mark;
  logic             mark_next;
  logic             out_free;
  logic             out_load;
  logic [1:0]        kind_next;
  logic [CH_W-1:0]   char_next;
  logic [IDX_W-1:0]  pos_next;
  logic [LEN_W-1:0]  cur_out_next;
  logic [LEN_W-1:0]  len_out_next;
  logic              term_out_next;
  logic              last_next;

  assign eff_width = (max_width > LINE_MAX_LEN) ? LINE_MAX_LEN : max_width;
  assign out_free  = !res_valid || !res_stall;
  assign ptr_inc   = ptr + 1'b1;
  // the shift reads one entry ahead of the one it writes
  assign raddr     = (state == B_SH_RD) ? ptr_inc[IDX_W-1:0] : ptr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_comb begin
    state_next    = state;
    cursor_next   = cursor;
    length_next   = length;
    ptr_next      = ptr;
    term_next     = term;
    mark_next     = mark;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = ptr[IDX_W-1:0];
    wdata         = rd_data;
    out_load      = 1'b0;
    kind_next     = KIND_STATUS;
    char_next     = '0;
    pos_next      = '0;
    cur_out_next  = cursor;
    len_out_next  = length;
    term_out_next = 1'b0;
    last_next     = 1'b1;

    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          mark_next  = 1'b0;
          state_next = B_STATUS;
          unique case (q_head.op)
            OP_LEFT: begin
              if (cursor != '0) begin
                cursor_next = cursor - 1'b1;
              end
            end
            OP_RIGHT: begin
              if (cursor < length) begin
                cursor_next = cursor + 1'b1;
              end
            end
            OP_HOME: cursor_next = '0;
            OP_END:  cursor_next = length;
            OP_DEL: begin
              if (cursor < length) begin
                ptr_next   = cursor;
                state_next = B_SH_RD;
              end
            end
            OP_BKSP: begin
              if (cursor != '0) begin
                ptr_next    = cursor - 1'b1;
                cursor_next = cursor - 1'b1;
                state_next  = B_SH_RD;
              end
            end
            OP_PRINT: begin
              waddr = cursor[IDX_W-1:0];
              wdata = q_head.ch;
              if (cursor < length) begin
                we          = 1'b1;
                cursor_next = cursor + 1'b1;
              end else if (cursor == length && length < eff_width) begin
                we          = 1'b1;
                cursor_next = cursor + 1'b1;
                length_next = length + 1'b1;
              end else begin
                // full line: key dropped without a result
                state_next = B_IDLE;
              end
            end
            OP_ENTER, OP_ESC: begin
              term_next = (q_head.op == OP_ESC);
              ptr_next  = '0;
              if (length == '0) begin
                mark_next   = 1'b1;
                cursor_next = '0;
              end else begin
                state_next = B_EM_RD;
              end
            end
            OP_STATUS: state_next = B_STATUS;
            default:   state_next = B_STATUS;
          endcase
        end
      end
      B_SH_RD: begin
        if (ptr_inc < length) begin
          state_next = B_SH_WR;
        end else begin
          length_next = length - 1'b1;
          state_next  = B_STATUS;
        end
      end
      B_SH_WR: begin
        we         = 1'b1;
        waddr      = ptr[IDX_W-1:0];
        wdata      = rd_data;
        ptr_next   = ptr_inc;
        state_next = B_SH_RD;
      end
      B_EM_RD: begin
        state_next = B_EM_OUT;
      end
      B_EM_OUT: begin
        if (out_free) begin
          out_load      = 1'b1;
          kind_next     = KIND_CHAR;
          char_next     = rd_data;
          pos_next      = ptr[IDX_W-1:0];
          cur_out_next  = '0;
          len_out_next  = '0;
          term_out_next = term;
          last_next     = (ptr_inc == length);
          if (ptr_inc == length) begin
            cursor_next = '0;
            length_next = '0;
            state_next  = B_IDLE;
          end else begin
            ptr_next   = ptr_inc;
            state_next = B_EM_RD;
          end
        end
      end
      B_STATUS: begin
        if (out_free) begin
          out_load      = 1'b1;
          kind_next     = mark ? KIND_END : KIND_STATUS;
          term_out_next = mark && term;
          state_next    = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cursor    <= '0;
      length    <= '0;
      max_width <= LINE_MAX_LEN;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      length <= length_next;
      if (cfg_valid) begin
        max_width <= cfg_data;
      end
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr  <= ptr_next;
    term <= term_next;
    mark <= mark_next;
    if (out_load) begin
      kind          <= kind_next;
      char_out      <= char_next;
      char_position <= pos_next;
      cursor_pos    <= cur_out_next;
      line_length   <= len_out_next;
      terminator    <= term_out_next;
      last          <= last_next;
    end
  end

endmodule

>>> design/keystroke_line_edit_buffer.sv
// top level of the keystroke line editor: front end, command queue, back end
// depends on kleb_pkg, kleb_front, kleb_queue, kleb_back
//
// Keystroke line editor. Raw keyboard bytes enter on key_valid/key_stall and
// results leave on res_valid/res_stall; the user must write max_width on
// cfg_valid/cfg_ready only while the editor is idle; the block itself does
// not enforce this (cfg_ready is always high). The front end takes one byte
// per cycle into a four-entry command queue while it has room, so key_stall
// only rises when four commands wait. The back end works one command at a
// time around a 64-entry line memory with one read and one write port and a
// registered read: a cursor move, overwrite, append or other status key goes
// straight to its status result; delete and backspace first shift the tail,
// one memory read and one write per character after the removed one; enter
// and escape read the line out as one character result per character, or
// give the end marker of an empty line. A printable key on a full line gives
// no result. A stalled result holds the back end; the front end keeps taking
// bytes until the queue is full. No clearing pass after reset.
module keystroke_line_edit_buffer import kleb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_data,
  input  logic              key_valid,
  output logic              key_stall,
  input  logic [7:0]        key_byte,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [1:0]        kind,
  output logic [CH_W-1:0]   char_out,
  output logic [IDX_W-1:0]  char_position,
  output logic [LEN_W-1:0]  cursor_pos,
  output logic [LEN_W-1:0]  line_length,
  output logic              terminator,
  output logic              last
);

  logic q_push;
  cmd_t q_cmd;
  logic q_full;
  logic q_pop;
  cmd_t q_head;
  logic q_empty;

  assign cfg_ready = 1'b1;

  kleb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_byte  (key_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  kleb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  kleb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .kind          (kind),
    .char_out      (char_out),
    .char_position (char_position),
    .cursor_pos    (cursor_pos),
    .line_length   (line_length),
    .terminator    (terminator),
    .last          (last)
  );

`ifndef SYNTH
  // a status never shows the cursor past the end of the line
  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_STATUS |-> cursor_pos <= line_length && !terminator)
    else $error("cursor beyond line length");

  // the line never grows past its capacity
  a_length_cap: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> line_length <= LINE_MAX_LEN)
    else $error("line length beyond capacity");

  // line read-out and end-marker results report zero cursor and length
  a_readout_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != KIND_STATUS |-> cursor_pos == '0 && line_length == '0)
    else $error("line read-out with nonzero cursor or length");

  // an empty-line marker is always the only result of its key
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_END |-> last && char_out == '0)
    else $error("end marker not final");
`endif

endmodule

>>> verif/keystroke_line_edit_buffer_tb.sv
// self-checking testbench for keystroke_line_edit_buffer: directed table, then random key phases
// depends on kleb_pkg and the keystroke_line_edit_buffer rtl
module keystroke_line_edit_buffer_tb;
  import kleb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int DRAIN_CYCLES  = 300;
  localparam int MAX_IDLE      = 17;
  localparam int PHASE_KEYS    = 10;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CH_W-1:0]  ch;
    logic [IDX_W-1:0] pos;
    logic [LEN_W-1:0] cur;
    logic [LEN_W-1:0] len;
    logic             term;
    logic             last;
  } edit_res_t;

  typedef struct packed {
    logic [7:0] key;
    logic       typed;
    edit_res_t  want;
  } key_row_t;

  // opening keys at reset width; typed rows carry their status or end marker
  localparam key_row_t OPENING_KEYS [26] = '{
    '{KEY_ENTER,    1'b1, '{KIND_END, 7'd0, 6'd0, 7'd0, 7'd0, 1'b0, 1'b1}},
    '{KEY_ESC,      1'b1, '{KIND_END, 7'd0, 6'd0, 7'd0, 7'd0, 1'b1, 1'b1}},
    '{KEY_BKSP,     1'b1, '{KIND_STATUS, 7'd0, 6'd0, 7'd0, 7'd0, 1'b0, 1'b1}},
    '{KEY_PREFIX_A, 1'b0, '0},
    '{KEY_LEFT,     1'b1, '{KIND_STATUS, 7'd0, 6'd0, 7'd0, 7'd0, 1'b0, 1'b1}},
    '{KEY_PREFIX_B, 1'b0, '0},
    '{KEY_RIGHT,    1'b1, '{KIND_STATUS, 7'd0, 6'd0, 7'd0, 7'd0, 1'b0, 1'b1}},
    '{8'h41,        1'b1, '{KIND_STATUS, 7'd0, 6'd0, 7'd1, 7'd1, 1'b0, 1'b1}},
    '{KEY_PRINT_LO, 1'b0, '0},
    '{KEY_PRINT_HI, 1'b0, '0},
    '{KEY_PREFIX_B, 1'b0, '0},
    '{KEY_HOME,     1'b1, '{KIND_STATUS, 7'd0, 6'd0, 7'd0, 7'd3, 1'b0, 1'b1}},
    '{8'h7A,        1'b0, '0},
    '{KEY_PREFIX_A, 1'b0, '0},
    '{KEY_DEL,      1'b0, '0},
    '{KEY_PREFIX_A, 1'b0, '0},
    '{KEY_PREFIX_A, 1'b0, '0},
    '{KEY_PREFIX_B, 1'b0, '0},
    '{KEY_END,      1'b0, '0},
    '{8'h7F,        1'b0, '0},
    '{8'hFF,        1'b0, '0},
    '{8'h01,        1'b0, '0},
    '{KEY_PREFIX_B, 1'b0, '0},
    '{KEY_PREFIX_B, 1'b0, '0},
    '{KEY_BKSP,     1'b0, '0},
    '{KEY_ENTER,    1'b0, '0}
  };

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data;
  logic             key_valid;
  logic             key_stall;
  logic [7:0]       key_byte;
  logic             res_valid;
  logic             res_stall;
  logic [1:0]       kind;
  logic [CH_W-1:0]  char_out;
  logic [IDX_W-1:0] char_position;
  logic [LEN_W-1:0] cursor_pos;
  logic [LEN_W-1:0] line_length;
  logic             terminator;
  logic             last;

  // editor state as the testbench sees it
  logic [CH_W-1:0]  line_copy [LINE_MAX];
  logic [LEN_W-1:0] cur_copy;
  logic [LEN_W-1:0] len_copy;
  logic             ext_armed;
  logic [LEN_W-1:0] width_now;

  edit_res_t due_results [$];
  int        mismatches;
  int        cycles;
  int        stall_left;
  bit        idle_on;

  keystroke_line_edit_buffer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .key_valid    (key_valid),
    .key_stall    (key_stall),
    .key_byte     (key_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .kind         (kind),
    .char_out     (char_out),
    .char_position(char_position),
    .cursor_pos   (cursor_pos),
    .line_length  (line_length),
    .terminator   (terminator),
    .last         (last)
  );

  always #5 clk = ~clk;

  function automatic edit_res_t mk_res(logic [1:0] k, logic [CH_W-1:0] ch,
                                       logic [IDX_W-1:0] pos, logic [LEN_W-1:0] cur,
                                       logic [LEN_W-1:0] len, logic term, logic lst);
    edit_res_t r;
    r.kind = k;
    r.ch   = ch;
    r.pos  = pos;
    r.cur  = cur;
    r.len  = len;
    r.term = term;
    r.last = lst;
    return r;
  endfunction

  // close the gap left by removing the character at position at
  function automatic void drop_char(logic [LEN_W-1:0] at);
    for (int i = at; i + 1 < len_copy; i++)
      line_copy[i] = line_copy[i + 1];
    len_copy--;
  endfunction

  function automatic void push_status();
    due_results.push_back(mk_res(KIND_STATUS, '0, '0, cur_copy, len_copy, 1'b0, 1'b1));
  endfunction

  // apply one key to the copy of the editor, queue what it emits, return the count
  function automatic int edit_key(logic [7:0] b);
    logic [LEN_W-1:0] wid;
    logic             term;
    int               n;
    wid = (width_now < LINE_MAX_LEN) ? width_now : LINE_MAX_LEN;
    if (ext_armed) begin
      ext_armed = 1'b0;
      case (b)
        KEY_LEFT:  if (cur_copy > 0) cur_copy--;
        KEY_RIGHT: if (cur_copy < len_copy) cur_copy++;
        KEY_HOME:  cur_copy = '0;
        KEY_END:   cur_copy = len_copy;
        KEY_DEL:   if (cur_copy < len_copy) drop_char(cur_copy);
        default: ;
      endcase
      push_status();
      return 1;
    end
    if (b == KEY_PREFIX_A || b == KEY_PREFIX_B) begin
      ext_armed = 1'b1;
      return 0;
    end
    if (b == KEY_ENTER || b == KEY_ESC) begin
      term = (b == KEY_ESC);
      if (len_copy == 0) begin
        due_results.push_back(mk_res(KIND_END, '0, '0, '0, '0, term, 1'b1));
        n = 1;
      end else begin
        for (int i = 0; i < len_copy; i++)
          due_results.push_back(mk_res(KIND_CHAR, line_copy[i], IDX_W'(i), '0, '0, term,
                                       (i + 1 == len_copy)));
        n = len_copy;
      end
      cur_copy = '0;
      len_copy = '0;
      return n;
    end
    if (b == KEY_BKSP) begin
      if (cur_copy > 0) begin
        drop_char(cur_copy - 1'b1);
        cur_copy--;
      end
    end else if (b >= KEY_PRINT_LO && b <= KEY_PRINT_HI) begin
      if (cur_copy < len_copy) begin
        line_copy[cur_copy] = b[CH_W-1:0];
      end else if (cur_copy == len_copy && len_copy < wid) begin
        line_copy[len_copy] = b[CH_W-1:0];
        len_copy++;
      end else begin
        // full line: key dropped without a result
        return 0;
      end
      cur_copy++;
    end
    push_status();
    return 1;
  endfunction

  task automatic flag(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_key(logic [7:0] b, logic typed = 1'b0, edit_res_t want = '0);
    int gap;
    int n;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      key_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_valid <= 1'b1;
    key_byte  <= b;
    @(posedge clk);
    while (key_stall) @(posedge clk);
    n = edit_key(b);
    if (typed) begin
      repeat (n) void'(due_results.pop_back());
      due_results.push_back(want);
    end
  endtask

  // width changes only once the editor has gone quiet
  task automatic set_width(logic [LEN_W-1:0] w);
    key_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    // dropped keys still in the command queue give no result, so let them drain
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    width_now = w;
  endtask

  task automatic rand_key();
    int         pick;
    logic [7:0] pfx;
    pick = $urandom_range(0, 99);
    pfx  = $urandom_range(0, 1) ? KEY_PREFIX_A : KEY_PREFIX_B;
    if (pick < 45) begin
      send_key(8'($urandom_range(KEY_PRINT_LO, KEY_PRINT_HI)));
    end else if (pick < 70) begin
      send_key(pfx);
      case ($urandom_range(0, 5))
        0: send_key(KEY_LEFT);
        1: send_key(KEY_RIGHT);
        2: send_key(KEY_HOME);
        3: send_key(KEY_END);
        4: send_key(KEY_DEL);
        default: send_key(8'($urandom));
      endcase
    end else if (pick < 82) begin
      send_key(KEY_BKSP);
    end else if (pick < 87) begin
      send_key($urandom_range(0, 1) ? KEY_ENTER : KEY_ESC);
    end else begin
      send_key(8'($urandom));
    end
  endtask

  task automatic run_phase(logic [LEN_W-1:0] w, int count, bit quiet);
    set_width(w);
    idle_on = !quiet;
    repeat (count) rand_key();
  endtask

  // result side: compare each accepted result, then draw a random stall while idle_on is set
  always @(posedge clk) begin : collect
    edit_res_t got;
    edit_res_t want;
    int        hold;
    if (rst) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else if (res_valid && !res_stall) begin
      got = mk_res(kind, char_out, char_position, cursor_pos, line_length, terminator, last);
      if (due_results.size() == 0) begin
        flag("unexpected result, kind", got.kind, 0);
      end else begin
        want = due_results.pop_front();
        if (got.kind != want.kind) flag("kind", got.kind, want.kind);
        if (got.ch != want.ch) flag("char_out", got.ch, want.ch);
        if (got.pos != want.pos) flag("char_position", got.pos, want.pos);
        if (got.cur != want.cur) flag("cursor_pos", got.cur, want.cur);
        if (got.len != want.len) flag("line_length", got.len, want.len);
        if (got.term != want.term) flag("terminator", got.term, want.term);
        if (got.last != want.last) flag("last", got.last, want.last);
      end
      hold = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      stall_left <= hold;
      res_stall  <= (hold != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_stall  <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    key_valid  = 1'b0;
    key_byte   = '0;
    cycles     = 0;
    mismatches = 0;
    idle_on    = 1'b1;
    cur_copy   = '0;
    len_copy   = '0;
    ext_armed  = 1'b0;
    width_now  = LINE_MAX_LEN;
    foreach (line_copy[i]) line_copy[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (OPENING_KEYS[i])
      send_key(OPENING_KEYS[i].key, OPENING_KEYS[i].typed, OPENING_KEYS[i].want);

    run_phase(7'd1, PHASE_KEYS, 1'b1);
    run_phase(7'd21, PHASE_KEYS, 1'b0);

    // fill to the widest line, overflow it, flush all of it, then a long tail shift
    set_width(LINE_MAX_LEN);
    idle_on = 1'b1;
    send_key(KEY_PREFIX_B);
    send_key(KEY_END);
    repeat (LINE_MAX + 2) send_key(8'($urandom_range(KEY_PRINT_LO, KEY_PRINT_HI)));
    send_key(KEY_ESC);
    repeat (40) send_key(8'($urandom_range(KEY_PRINT_LO, KEY_PRINT_HI)));
    send_key(KEY_PREFIX_A);
    send_key(KEY_HOME);
    send_key(KEY_PREFIX_A);
    send_key(KEY_DEL);

    // width now below the held length: overwrites still land, appends are refused
    run_phase(7'd2, PHASE_KEYS, 1'b0);
    run_phase(7'd40, PHASE_KEYS, 1'b0);
    run_phase(7'd3, PHASE_KEYS, 1'b0);
    run_phase(LINE_MAX_LEN, PHASE_KEYS, 1'b1);

    key_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
